FILE: rtl/lfd_pkg.sv
// shared widths, fixed controller constants and the output saturation helper
// for the line-follow drive controller; no dependencies
package lfd_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 30;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // accumulator for the two-term sums
  localparam int ACC_W = 43;

  // negative distance drive is clamped to this signed width before scaling
  localparam int NEG_CLAMP_W = 29;

  // speed outputs and the width fed to the saturation helper
  localparam int OUT_W    = 12;
  localparam int SAT_IN_W = 32;

  // line rotation term
  localparam int ROT_W = 20;

  // fixed thresholds and gains
  localparam logic [7:0]  DIST_DEADBAND   = 8'd10;
  localparam logic [7:0]  LINE_DEADBAND   = 8'd5;
  localparam logic [15:0] SOUND_THRESHOLD = 16'd10000;
  localparam logic [9:0]  WIDTH_THRESHOLD = 10'd200;
  localparam logic [7:0]  RANGE_OFFSET    = 8'd40;
  localparam logic [12:0] REVERSE_GAIN    = 13'd512;

  // clamp a signed value into the 12 bit speed range
  function automatic logic signed [OUT_W-1:0] sat12(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(2047);
    lo = -SAT_IN_W'(2048);
    if (v > hi) begin
      return OUT_W'(2047);
    end else if (v < lo) begin
      return OUT_W'(2048);
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/line_follow_pi_pd_drive.sv
// line-follow drive controller top level: register port, sequencer and datapath
// depends on lfd_pkg and lfd_mul
//
//   channel   direction  handshake               beat contents
//   cfg       in / out   psel penable pwrite     8 registers at byte address 4*i
//   in        in         in_valid_i in_stall_o   sound, line error, width, range
//   out       out        out_valid_o out_stall_i left, right speed, corner flag
//
// one beat in gives one beat out; the cruise and corner paths step through S_CHK,
// S_LD, S_LACC, S_LROT and S_SEL to S_DONE (a line error inside the deadband
// skips S_LD to S_LROT, a silent beat goes from S_CHK to S_DONE) and the distance
// regulator path adds S_INT to S_DRV and, for reverse drive, S_NEG, set by the
// passes through the single shared multiplier; a new beat waits for S_IDLE
// in_stall_o stays high while a beat is being worked on
// a finished result waits in the staging registers while the output is stalled,
// holding the sequencer in S_DONE; no next beat is accepted meanwhile
// reset is asynchronous and restores the register defaults and clears
// the integrator and the stored line error
module line_follow_pi_pd_drive (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        sound_level_i,
  input  logic signed [9:0]                  line_error_i,
  input  logic [9:0]                         line_width_i,
  input  logic [11:0]                        range_mm_i,
  // output beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lfd_pkg::OUT_W-1:0]   left_speed_o,
  output logic signed [lfd_pkg::OUT_W-1:0]   right_speed_o,
  output logic                               corner_seen_o
);
  import lfd_pkg::*;

  // register indexes
  localparam logic [2:0] REG_BASE_SPEED    = 3'd0;
  localparam logic [2:0] REG_TARGET_DIST   = 3'd1;
  localparam logic [2:0] REG_DETECT_DIST   = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_LIM  = 3'd3;
  localparam logic [2:0] REG_DIST_P_GAIN   = 3'd4;
  localparam logic [2:0] REG_DIST_I_GAIN   = 3'd5;
  localparam logic [2:0] REG_LINE_P_GAIN   = 3'd6;
  localparam logic [2:0] REG_LINE_D_GAIN   = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a beat
    S_CHK,    // sound gate, line deadband; issue line_p * e
    S_LD,     // load first product; issue line_d * (e - prev)
    S_LACC,   // add second product, store e as previous
    S_LROT,   // rotation = acc / 256 toward zero
    S_SEL,    // corner / obstacle / cruise decision
    S_INT,    // integrator update with clamp
    S_PM,     // issue dist_p * err
    S_IM,     // load product; issue dist_i * integral
    S_SACC,   // add second product
    S_DRV,    // positive drive or issue reverse scaling
    S_NEG,    // reverse drive = product / 65536 toward zero
    S_DONE    // hand result to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] base_q;
  logic [11:0] target_q;
  logic [11:0] detect_q;
  logic [22:0] ilim_q;
  logic [15:0] dpg_q;
  logic [15:0] dig_q;
  logic [15:0] lpg_q;
  logic [15:0] ldg_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 11'd600;
      target_q <= 12'd30;
      detect_q <= 12'd200;
      ilim_q   <= 23'd2000;
      dpg_q    <= 16'd2560;
      dig_q    <= 16'd64;
      lpg_q    <= 16'd512;
      ldg_q    <= 16'd256;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_SPEED:   base_q   <= pwdata[10:0];
        REG_TARGET_DIST:  target_q <= pwdata[11:0];
        REG_DETECT_DIST:  detect_q <= pwdata[11:0];
        REG_INTEGRAL_LIM: ilim_q   <= pwdata[22:0];
        REG_DIST_P_GAIN:  dpg_q    <= pwdata[15:0];
        REG_DIST_I_GAIN:  dig_q    <= pwdata[15:0];
        REG_LINE_P_GAIN:  lpg_q    <= pwdata[15:0];
        REG_LINE_D_GAIN:  ldg_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_SPEED:   prdata = {21'd0, base_q};
      REG_TARGET_DIST:  prdata = {20'd0, target_q};
      REG_DETECT_DIST:  prdata = {20'd0, detect_q};
      REG_INTEGRAL_LIM: prdata = {9'd0, ilim_q};
      REG_DIST_P_GAIN:  prdata = {16'd0, dpg_q};
      REG_DIST_I_GAIN:  prdata = {16'd0, dig_q};
      REG_LINE_P_GAIN:  prdata = {16'd0, lpg_q};
      REG_LINE_D_GAIN:  prdata = {16'd0, ldg_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer state, captured beat, controller state and result staging
  // ---------------------------------------------------------------------------
  state_e                    state_q;
  logic [15:0]               sound_q;
  logic signed [9:0]         e_q;
  logic [9:0]                width_q;
  logic [11:0]               range_q;
  logic signed [9:0]         prev_q;       // previous line error
  logic signed [23:0]        isum_q;       // distance integrator
  logic signed [13:0]        err_q;        // distance error of this beat
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ROT_W-1:0]   rot_q;
  logic signed [OUT_W-1:0]   res_left_q;
  logic signed [OUT_W-1:0]   res_right_q;
  logic                      res_corner_q;
  logic                      out_valid_q;
  logic signed [OUT_W-1:0]   left_q;
  logic signed [OUT_W-1:0]   right_q;
  logic                      corner_q;

  // ---------------------------------------------------------------------------
  // datapath around the shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [10:0]        e_ext;
  logic [10:0]               e_abs;
  logic [10:0]               prev_abs;
  logic signed [10:0]        e_diff;
  logic                      line_db;
  logic signed [12:0]        d_val;        // corrected range
  logic                      obstacle;
  logic signed [13:0]        err_val;
  logic [13:0]               err_abs;
  logic                      dist_off;
  logic signed [24:0]        isum_sum;
  logic signed [24:0]        lim_pos;
  logic signed [24:0]        isum_clamped;
  logic signed [23:0]        isum_next;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   acc_shr8;
  logic signed [ACC_W-1:0]   rot_full;
  logic [NEG_CLAMP_W-1:0]    s_clamp;
  logic signed [ACC_W-1:0]   base_q8;
  logic signed [SAT_IN_W-1:0] pos_v;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [PROD_W-1:0]  prod_shr16;
  logic signed [SAT_IN_W-1:0] neg_v;
  logic signed [SAT_IN_W-1:0] base32;
  logic signed [SAT_IN_W-1:0] rot32;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic                      out_free;

  // line error magnitude and difference
  assign e_ext    = {e_q[9], e_q};
  assign e_abs    = e_q[9] ? 11'(-e_ext) : 11'(e_ext);
  assign prev_abs = prev_q[9] ? 11'(-{prev_q[9], prev_q}) : 11'({prev_q[9], prev_q});
  assign e_diff   = e_ext - {prev_q[9], prev_q};
  assign line_db  = e_abs < {3'd0, LINE_DEADBAND};

  // obstacle test and distance error
  assign d_val    = $signed({1'b0, range_q}) - $signed({5'd0, RANGE_OFFSET});
  assign obstacle = $signed({d_val[12], d_val}) < $signed({2'b00, detect_q});
  assign err_val  = $signed({d_val[12], d_val}) - $signed({2'b00, target_q});
  assign err_abs  = err_val[13] ? 14'(-err_val) : 14'(err_val);
  assign dist_off = (err_abs < {6'd0, DIST_DEADBAND}) || (err_abs > {2'b00, detect_q});

  // integrator with symmetric clamp
  assign isum_sum = {isum_q[23], isum_q} + {{11{err_q[13]}}, err_q};
  assign lim_pos  = $signed({2'b00, ilim_q});
  always_comb begin
    if (isum_sum > lim_pos) begin
      isum_clamped = lim_pos;
    end else if (isum_sum < -lim_pos) begin
      isum_clamped = -lim_pos;
    end else begin
      isum_clamped = isum_sum;
    end
  end
  assign isum_next = isum_clamped[23:0];

  // rotation: divide by 256 rounding toward zero
  assign acc_rnd  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign rot_full = acc_rnd >>> 8;

  // reverse drive input: past the clamp the scaled result saturates anyway
  assign s_clamp = (&acc_q[ACC_W-1:NEG_CLAMP_W-1]) ? acc_q[NEG_CLAMP_W-1:0]
                                                   : {1'b1, {(NEG_CLAMP_W-1){1'b0}}};

  // forward drive: capped at base speed
  assign base_q8  = $signed({{(ACC_W-19){1'b0}}, base_q, 8'd0});
  assign acc_shr8 = acc_q >>> 8;
  assign pos_v    = (acc_q > base_q8) ? $signed({21'd0, base_q}) : acc_shr8[SAT_IN_W-1:0];

  // reverse drive: divide by 65536 rounding toward zero
  assign prod_rnd   = prod + (prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign prod_shr16 = prod_rnd >>> 16;
  assign neg_v      = prod_shr16[SAT_IN_W-1:0];

  // cruise terms
  assign base32 = $signed({21'd0, base_q});
  assign rot32  = {{(SAT_IN_W-ROT_W){rot_q[ROT_W-1]}}, rot_q};

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    case (state_q)
      S_CHK: begin
        mul_a = $signed({1'b0, lpg_q});
        mul_b = {{(MUL_B_W-10){e_q[9]}}, e_q};
      end
      S_LD: begin
        mul_a = $signed({1'b0, ldg_q});
        mul_b = {{(MUL_B_W-11){e_diff[10]}}, e_diff};
      end
      S_PM: begin
        mul_a = $signed({1'b0, dpg_q});
        mul_b = {{(MUL_B_W-14){err_q[13]}}, err_q};
      end
      S_IM: begin
        mul_a = $signed({1'b0, dig_q});
        mul_b = {{(MUL_B_W-24){isum_q[23]}}, isum_q};
      end
      S_DRV: begin
        mul_a = $signed({{(MUL_A_W-13){1'b0}}, REVERSE_GAIN});
        mul_b = {{(MUL_B_W-NEG_CLAMP_W){s_clamp[NEG_CLAMP_W-1]}}, s_clamp};
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  lfd_mul #(
    .AW (MUL_A_W),
    .BW (MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // output register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sound_q      <= '0;
      e_q          <= '0;
      width_q      <= '0;
      range_q      <= '0;
      prev_q       <= '0;
      isum_q       <= '0;
      err_q        <= '0;
      acc_q        <= '0;
      rot_q        <= '0;
      res_left_q   <= '0;
      res_right_q  <= '0;
      res_corner_q <= 1'b0;
      out_valid_q  <= 1'b0;
      left_q       <= '0;
      right_q      <= '0;
      corner_q     <= 1'b0;
    end else begin
      // output beat loaded at hand-off, dropped once downstream took it
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sound_q <= sound_level_i;
            e_q     <= line_error_i;
            width_q <= line_width_i;
            range_q <= range_mm_i;
            state_q <= S_CHK;
          end
        end

        S_CHK: begin
          if (sound_q <= SOUND_THRESHOLD) begin
            // silent: all zero, no state change
            res_left_q   <= '0;
            res_right_q  <= '0;
            res_corner_q <= 1'b0;
            state_q      <= S_DONE;
          end else if (line_db) begin
            rot_q   <= '0;
            state_q <= S_SEL;
          end else begin
            state_q <= S_LD;
          end
        end

        S_LD: begin
          acc_q   <= prod[ACC_W-1:0];
          state_q <= S_LACC;
        end

        S_LACC: begin
          acc_q   <= acc_q + prod[ACC_W-1:0];
          prev_q  <= e_q;
          state_q <= S_LROT;
        end

        S_LROT: begin
          rot_q   <= rot_full[ROT_W-1:0];
          state_q <= S_SEL;
        end

        S_SEL: begin
          if (width_q > WIDTH_THRESHOLD) begin
            // wide line: corner request, wheels stopped
            res_left_q   <= '0;
            res_right_q  <= '0;
            res_corner_q <= 1'b1;
            state_q      <= S_DONE;
          end else if (obstacle) begin
            res_corner_q <= 1'b0;
            if (dist_off) begin
              // inside the deadband or past the cutoff: stop, integrator kept
              res_left_q  <= '0;
              res_right_q <= '0;
              state_q     <= S_DONE;
            end else begin
              err_q   <= err_val;
              state_q <= S_INT;
            end
          end else begin
            res_left_q   <= sat12(base32 + rot32);
            res_right_q  <= sat12(base32 - rot32);
            res_corner_q <= 1'b0;
            state_q      <= S_DONE;
          end
        end

        S_INT: begin
          isum_q  <= isum_next;
          state_q <= S_PM;
        end

        S_PM: begin
          state_q <= S_IM;
        end

        S_IM: begin
          acc_q   <= prod[ACC_W-1:0];
          state_q <= S_SACC;
        end

        S_SACC: begin
          acc_q   <= acc_q + prod[ACC_W-1:0];
          state_q <= S_DRV;
        end

        S_DRV: begin
          if (acc_q[ACC_W-1]) begin
            state_q <= S_NEG;
          end else begin
            res_left_q  <= sat12(pos_v);
            res_right_q <= sat12(pos_v);
            state_q     <= S_DONE;
          end
        end

        S_NEG: begin
          res_left_q  <= sat12(neg_v);
          res_right_q <= sat12(neg_v);
          state_q     <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            left_q      <= res_left_q;
            right_q     <= res_right_q;
            corner_q    <= res_corner_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign corner_seen_o = corner_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an accepted beat keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a corner request always comes with stopped wheels
  a_corner_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && corner_seen_o |-> left_speed_o == '0 && right_speed_o == '0)
    else $error("corner beat with nonzero speed");

  // stored line error is only ever taken from outside the deadband
  a_prev_outside_db: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_q == '0 || prev_abs >= {3'd0, LINE_DEADBAND})
    else $error("stored line error inside deadband");

  // a new output beat only comes from the hand-off step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(state_q == S_DONE))
    else $error("output valid without hand-off");

endmodule

FILE: rtl/lfd_mul.sv
// shared signed multiplier with a registered product
// depends on lfd_pkg for the default operand widths
module lfd_mul #(
  parameter int AW = lfd_pkg::MUL_A_W,
  parameter int BW = lfd_pkg::MUL_B_W
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import lfd_pkg::*;

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule
